// File: design/xlsf_pkg.sv
package xlsf_pkg;

   typedef enum logic [3:0] {
      OP_TEST  = 4'd0,
      OP_AND   = 4'd1,
      OP_XOR   = 4'd2,
      OP_OR    = 4'd3,
      OP_SAR   = 4'd4,
      OP_SHL   = 4'd5,
      OP_SHR   = 4'd6,
      OP_ROL   = 4'd7,
      OP_NOT   = 4'd8,
      OP_SETCC = 4'd9
   } op_type;

   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;

   // Condition groups: the condition code without its invert bit.
   localparam logic [2:0] CC_O  = 3'd0;
   localparam logic [2:0] CC_B  = 3'd1;
   localparam logic [2:0] CC_E  = 3'd2;
   localparam logic [2:0] CC_BE = 3'd3;
   localparam logic [2:0] CC_S  = 3'd4;
   localparam logic [2:0] CC_P  = 3'd5;
   localparam logic [2:0] CC_L  = 3'd6;
   localparam logic [2:0] CC_LE = 3'd7;

   typedef struct packed {
      logic cf;
      logic of;
      logic zf;
      logic sf;
   } flags_type;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [31:0] dest_value;
      logic [31:0] src_value;
      logic [1:0]  size_code;
      logic [3:0]  cond_code;
   } req_data_type;

   typedef struct packed {
      logic [31:0] result;
      logic        write_back;
      flags_type   flags;
      logic        unsupported;
   } rsp_data_type;

endpackage

// File: design/xlsf_if.sv
interface xlsf_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [31:0] dest_value;
   logic [31:0] src_value;
   logic [1:0]  size_code;
   logic [3:0]  cond_code;

   modport source (output valid, output req_type, output dest_value, output src_value,
                   output size_code, output cond_code, input ready);
   modport sink (input valid, input req_type, input dest_value, input src_value,
                 input size_code, input cond_code, output ready);
endinterface

interface xlsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result;
   logic        write_back;
   logic        carry_flag;
   logic        overflow_flag;
   logic        zero_flag;
   logic        sign_flag;
   logic        unsupported;

   modport source (output valid, output result, output write_back, output carry_flag,
                   output overflow_flag, output zero_flag, output sign_flag,
                   output unsupported, input ready);
   modport sink (input valid, input result, input write_back, input carry_flag,
                 input overflow_flag, input zero_flag, input sign_flag,
                 input unsupported, output ready);
endinterface

// File: design/xlsf_exec.sv
module xlsf_exec
   import xlsf_pkg::*;
(
   input  req_data_type req,
   input  flags_type    flags_cur,
   output rsp_data_type rsp
);

   always_comb begin
      logic [31:0] mask;
      logic [31:0] top;
      logic [31:0] d;
      logic [31:0] s;
      logic [31:0] sx;
      logic [31:0] res;
      logic [31:0] rot_res;
      logic [4:0]  cnt;
      logic [15:0] rot8;
      logic [31:0] rot16;
      logic [63:0] rot32;
      logic        cond;
      flags_type   fl;

      unique case (req.size_code)
         SIZE_BYTE: begin
            mask = 32'h0000_00FF;
            top  = 32'h0000_0080;
         end
         SIZE_WORD: begin
            mask = 32'h0000_FFFF;
            top  = 32'h0000_8000;
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            top  = 32'h8000_0000;
         end
      endcase

      d   = req.dest_value & mask;
      s   = req.src_value;
      cnt = s[4:0];

      unique case (req.size_code)
         SIZE_BYTE: sx = {{24{d[7]}}, d[7:0]};
         SIZE_WORD: sx = {{16{d[15]}}, d[15:0]};
         default:   sx = d;
      endcase

      // Rotation inside the operand width equals the bit-by-bit loop.
      rot8  = {d[7:0], d[7:0]} << cnt[2:0];
      rot16 = {d[15:0], d[15:0]} << cnt[3:0];
      rot32 = {d, d} << cnt;
      unique case (req.size_code)
         SIZE_BYTE: rot_res = {24'd0, rot8[15:8]};
         SIZE_WORD: rot_res = {16'd0, rot16[31:16]};
         default:   rot_res = rot32[63:32];
      endcase

      unique case (req.cond_code[3:1])
         CC_O:    cond = flags_cur.of;
         CC_B:    cond = flags_cur.cf;
         CC_E:    cond = flags_cur.zf;
         CC_BE:   cond = flags_cur.cf | flags_cur.zf;
         CC_S:    cond = flags_cur.sf;
         CC_P:    cond = 1'b0;
         CC_L:    cond = flags_cur.sf ^ flags_cur.of;
         CC_LE:   cond = flags_cur.zf | (flags_cur.sf ^ flags_cur.of);
         default: cond = 1'b0;
      endcase
      cond = cond ^ req.cond_code[0];

      res             = 32'd0;
      fl              = flags_cur;
      rsp.write_back  = 1'b0;
      rsp.unsupported = 1'b0;

      unique case (op_type'(req.req_type))
         OP_TEST, OP_AND, OP_XOR, OP_OR: begin
            unique case (op_type'(req.req_type))
               OP_XOR:  res = (d ^ s) & mask;
               OP_OR:   res = (d | s) & mask;
               default: res = d & s & mask;
            endcase
            rsp.write_back = (op_type'(req.req_type) != OP_TEST);
            fl.cf = 1'b0;
            fl.of = 1'b0;
            fl.zf = (res == 32'd0);
            fl.sf = |(res & top);
         end
         OP_SAR, OP_SHL, OP_SHR: begin
            unique case (op_type'(req.req_type))
               OP_SAR:  res = 32'($signed(sx) >>> cnt) & mask;
               OP_SHL:  res = (d << cnt) & mask;
               default: res = d >> cnt;
            endcase
            rsp.write_back = 1'b1;
            fl.zf = (res == 32'd0);
            fl.sf = |(res & top);
         end
         OP_ROL: begin
            res            = rot_res;
            rsp.write_back = 1'b1;
            if (cnt != 5'd0) begin
               // The last bit rotated out lands in bit 0, the one before it in bit 1.
               fl.cf = rot_res[0];
               fl.of = rot_res[0] ^ ((cnt == 5'd1) ? flags_cur.cf : rot_res[1]);
            end
         end
         OP_NOT: begin
            res            = (~d) & mask;
            rsp.write_back = 1'b1;
         end
         OP_SETCC: begin
            if (req.cond_code[3:1] == CC_P) begin
               rsp.unsupported = 1'b1;
            end else begin
               res            = {31'd0, cond};
               rsp.write_back = 1'b1;
            end
         end
         default: begin
            res = 32'd0;
         end
      endcase

      rsp.result = res;
      rsp.flags  = fl;
   end

endmodule

// File: design/x86_logic_shift_flags_unit_core.sv
// An accepted request waits in the input register until the result register is free.
// Throughput: one transaction per cycle unless stalled; the flag file is updated
// as an instruction moves from the input register into the result register, so the
// next one sees it.
// Reset (synchronous, active high) clears both valid bits and CF, OF, ZF and SF.
module x86_logic_shift_flags_unit_core
   import xlsf_pkg::*;
(
   input logic          clock,
   input logic          reset,
   xlsf_req_if.sink     req_ch,
   xlsf_rsp_if.source   rsp_ch
);

   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff;
   flags_type    flags_ff;
   rsp_data_type exec_rsp;
   logic         s1_adv;
   logic         req_take;

   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;

   xlsf_exec u_exec (
      .req       (s1_data_ff),
      .flags_cur (flags_ff),
      .rsp       (exec_rsp)
   );

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (s1_valid_ff && !s1_adv);
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            flags_ff <= exec_rsp.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff.req_type   <= req_ch.req_type;
         s1_data_ff.dest_value <= req_ch.dest_value;
         s1_data_ff.src_value  <= req_ch.src_value;
         s1_data_ff.size_code  <= req_ch.size_code;
         s1_data_ff.cond_code  <= req_ch.cond_code;
      end
      if (s1_adv) begin
         out_data_ff <= exec_rsp;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.result        = out_data_ff.result;
   assign rsp_ch.write_back    = out_data_ff.write_back;
   assign rsp_ch.carry_flag    = out_data_ff.flags.cf;
   assign rsp_ch.overflow_flag = out_data_ff.flags.of;
   assign rsp_ch.zero_flag     = out_data_ff.flags.zf;
   assign rsp_ch.sign_flag     = out_data_ff.flags.sf;
   assign rsp_ch.unsupported   = out_data_ff.unsupported;

`ifndef NO_ASSERTIONS
   // The flag file always matches the flags of the most recent result.
   a_flags_track: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (flags_ff == out_data_ff.flags))
      else $error("flag file differs from the pending result's flags");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("input register lost a transaction");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("request not ready with an empty input register");

   a_unsupported: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.unsupported) |->
         (!out_data_ff.write_back && out_data_ff.result == 32'd0))
      else $error("unsupported condition produced a write-back");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
   import xlsf_pkg::*;

   localparam logic [1:0] SIZE_ODD        = 2'd3;
   localparam logic [3:0] FIRST_UNUSED_OP = 4'd10;
   localparam logic [3:0] LAST_UNUSED_OP  = 4'd15;
   localparam int         QUIET_LIMIT     = 1000;
   localparam int         MAX_PRINTED     = 40;

   logic clock;
   logic reset;

   xlsf_req_if req_ch();
   xlsf_rsp_if rsp_ch();

   x86_logic_shift_flags_unit_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   flags_type    flag_file;
   rsp_data_type exec_results_q[$];
   int           errors        = 0;
   int           instrs_sent   = 0;
   int           results_seen  = 0;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   int           hold_left     = 0;
   int           quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Executes one instruction against the flag file and returns what the block should emit.
   function automatic rsp_data_type execute_instr(req_data_type rq);
      rsp_data_type r;
      logic [31:0]  mask;
      logic [31:0]  top;
      logic [31:0]  d;
      logic [31:0]  v;
      logic [31:0]  sx;
      logic [4:0]   cnt;
      logic         msb;
      logic         cond;
      int           i;
      r = '0;
      v = '0;
      case (rq.size_code)
         SIZE_BYTE: begin
            mask = 32'h0000_00ff;
            top  = 32'h0000_0080;
         end
         SIZE_WORD: begin
            mask = 32'h0000_ffff;
            top  = 32'h0000_8000;
         end
         default: begin
            mask = 32'hffff_ffff;
            top  = 32'h8000_0000;
         end
      endcase
      d   = rq.dest_value & mask;
      cnt = rq.src_value[4:0];
      case (rq.req_type)
         OP_TEST, OP_AND, OP_XOR, OP_OR: begin
            if (rq.req_type == OP_XOR) v = (d ^ rq.src_value) & mask;
            else if (rq.req_type == OP_OR) v = (d | rq.src_value) & mask;
            else v = d & rq.src_value & mask;
            r.result     = v;
            r.write_back = (rq.req_type != OP_TEST);
            flag_file.cf = 1'b0;
            flag_file.of = 1'b0;
            flag_file.zf = ((v & mask) == 32'h0);
            flag_file.sf = ((v & top) != 32'h0);
         end
         OP_SAR, OP_SHL, OP_SHR: begin
            if (rq.req_type == OP_SAR) begin
               // Sign-extend from the operand size, then shift as a full word.
               sx = d;
               if ((d & top) != 32'h0) sx = sx | ~mask;
               v = $signed(sx) >>> cnt;
            end else if (rq.req_type == OP_SHL) begin
               v = d << cnt;
            end else begin
               v = d >> cnt;
            end
            v            = v & mask;
            r.result     = v;
            r.write_back = 1'b1;
            flag_file.zf = ((v & mask) == 32'h0);
            flag_file.sf = ((v & top) != 32'h0);
         end
         OP_ROL: begin
            v = d;
            for (i = 0; i < int'(cnt); i++) begin
               msb          = ((v & top) != 32'h0);
               flag_file.of = msb ^ flag_file.cf;
               v            = ((v << 1) & mask) | {31'b0, msb};
               flag_file.cf = msb;
            end
            r.result     = v;
            r.write_back = 1'b1;
         end
         OP_NOT: begin
            r.result     = ~d & mask;
            r.write_back = 1'b1;
         end
         OP_SETCC: begin
            case (rq.cond_code[3:1])
               CC_O:    cond = flag_file.of;
               CC_B:    cond = flag_file.cf;
               CC_E:    cond = flag_file.zf;
               CC_BE:   cond = flag_file.cf | flag_file.zf;
               CC_S:    cond = flag_file.sf;
               CC_P:    cond = 1'b0;
               CC_L:    cond = flag_file.sf ^ flag_file.of;
               default: cond = flag_file.zf | (flag_file.sf ^ flag_file.of);
            endcase
            if (rq.cond_code[3:1] == CC_P) begin
               r.unsupported = 1'b1;
            end else begin
               r.result     = {31'b0, cond ^ rq.cond_code[0]};
               r.write_back = 1'b1;
            end
         end
         default: ;
      endcase
      r.flags = flag_file;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("tb: mismatch on %s (result %0d): got %h, want %h",
                  what, results_seen, got, want);
   endtask

   // Predict on every accepted request, check every accepted result.
   always @(posedge clock) begin
      rsp_data_type want;
      req_data_type rq;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            rq.req_type   = req_ch.req_type;
            rq.dest_value = req_ch.dest_value;
            rq.src_value  = req_ch.src_value;
            rq.size_code  = req_ch.size_code;
            rq.cond_code  = req_ch.cond_code;
            exec_results_q.push_back(execute_instr(rq));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (exec_results_q.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_ch.result, 32'h0);
            end else begin
               want = exec_results_q.pop_front();
               if (rsp_ch.result !== want.result)
                  report_mismatch("result", rsp_ch.result, want.result);
               if (rsp_ch.write_back !== want.write_back)
                  report_mismatch("write_back", 32'(rsp_ch.write_back),
                                  32'(want.write_back));
               if (rsp_ch.carry_flag !== want.flags.cf)
                  report_mismatch("carry_flag", 32'(rsp_ch.carry_flag),
                                  32'(want.flags.cf));
               if (rsp_ch.overflow_flag !== want.flags.of)
                  report_mismatch("overflow_flag", 32'(rsp_ch.overflow_flag),
                                  32'(want.flags.of));
               if (rsp_ch.zero_flag !== want.flags.zf)
                  report_mismatch("zero_flag", 32'(rsp_ch.zero_flag),
                                  32'(want.flags.zf));
               if (rsp_ch.sign_flag !== want.flags.sf)
                  report_mismatch("sign_flag", 32'(rsp_ch.sign_flag),
                                  32'(want.flags.sf));
               if (rsp_ch.unsupported !== want.unsupported)
                  report_mismatch("unsupported", 32'(rsp_ch.unsupported),
                                  32'(want.unsupported));
            end
         end
      end
   end

   // The receiver either honors a requested hold-off or stalls at random.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_instr(logic [3:0] kind, logic [31:0] dst, logic [31:0] src,
                             logic [1:0] opnd_size, logic [3:0] cc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.dest_value <= dst;
      req_ch.src_value  <= src;
      req_ch.size_code  <= opnd_size;
      req_ch.cond_code  <= cc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      instrs_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0:       return 32'h0;
         1:       return 32'hffff_ffff;
         2:       return 32'h1 << $urandom_range(31);
         3:       return ~(32'h1 << $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_instr();
      logic [3:0] kind;
      logic [1:0] opnd_size;
      if ($urandom_range(9) == 0)
         kind = 4'($urandom_range(int'(LAST_UNUSED_OP), int'(FIRST_UNUSED_OP)));
      else
         kind = 4'($urandom_range(int'(OP_SETCC)));
      opnd_size = ($urandom_range(7) == 0) ? SIZE_ODD : 2'($urandom_range(int'(SIZE_DWORD)));
      send_instr(kind, pick_operand(), pick_operand(), opnd_size, 4'($urandom_range(15)));
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (exec_results_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic test_logic_ops();
      send_instr(OP_AND,  32'hffff_ffff, 32'hffff_ffff, SIZE_DWORD, 4'h0);
      send_instr(OP_TEST, 32'h0000_000f, 32'h0000_00f0, SIZE_BYTE,  4'h0);
      send_instr(OP_XOR,  32'h1234_8000, 32'h0000_0000, SIZE_WORD,  4'h0);
      send_instr(OP_OR,   32'h0000_0000, 32'hffff_ff00, SIZE_BYTE,  4'h0);
      wait_for_results();
   endtask

   task automatic test_shifts();
      send_instr(OP_SAR, 32'h0000_0080, 32'd3,  SIZE_BYTE,  4'h0);
      send_instr(OP_SAR, 32'h8000_0000, 32'd31, SIZE_DWORD, 4'h0);
      send_instr(OP_SAR, 32'hffff_7fff, 32'd33, SIZE_WORD,  4'h0);
      send_instr(OP_SHL, 32'h0000_0081, 32'd1,  SIZE_BYTE,  4'h0);
      send_instr(OP_SHL, 32'h0000_ffff, 32'd16, SIZE_WORD,  4'h0);
      send_instr(OP_SHR, 32'hffff_ffff, 32'd31, SIZE_DWORD, 4'h0);
      wait_for_results();
   endtask

   task automatic test_rotate();
      send_instr(OP_ROL, 32'h0000_0081, 32'd1,  SIZE_BYTE,  4'h0);
      send_instr(OP_ROL, 32'h8000_0000, 32'd0,  SIZE_DWORD, 4'h0);
      send_instr(OP_ROL, 32'h0000_c000, 32'd31, SIZE_WORD,  4'h0);
      send_instr(OP_ROL, 32'h0000_0055, 32'd32, SIZE_BYTE,  4'h0);
      wait_for_results();
   endtask

   task automatic test_not_and_setcc();
      send_instr(OP_NOT,   32'h0000_0000, 32'h0, SIZE_DWORD, 4'h0);
      send_instr(OP_SETCC, 32'h0000_0000, 32'h0, SIZE_BYTE,  {CC_E, 1'b0});
      send_instr(OP_SETCC, 32'h0000_0000, 32'h0, SIZE_WORD,  {CC_B, 1'b1});
      send_instr(OP_SETCC, 32'h0000_0000, 32'h0, SIZE_BYTE,  {CC_P, 1'b0});
      send_instr(OP_SETCC, 32'h0000_0000, 32'h0, SIZE_BYTE,  {CC_P, 1'b1});
      send_instr(OP_SETCC, 32'hffff_ffff, 32'h0, SIZE_ODD,   {CC_LE, 1'b1});
      wait_for_results();
   endtask

   task automatic test_odd_codes();
      send_instr(OP_AND,          32'h8000_0001, 32'hffff_ffff, SIZE_ODD,   4'h0);
      send_instr(FIRST_UNUSED_OP, 32'hffff_ffff, 32'hffff_ffff, SIZE_DWORD, 4'hf);
      send_instr(LAST_UNUSED_OP,  32'h1234_5678, 32'h0,         SIZE_BYTE,  4'h0);
      wait_for_results();
   endtask

   // The receiver holds off while the sender keeps offering, so the block backs up.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 80;
      repeat (30) send_random_instr();
      wait_for_results();
   endtask

   task automatic test_random(int count, int idle_pct, int rcv_stall_pct);
      send_idle_pct = idle_pct;
      stall_pct     = rcv_stall_pct;
      repeat (count) send_random_instr();
      wait_for_results();
   endtask

   initial begin
      flag_file         = '0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = '0;
      req_ch.dest_value = '0;
      req_ch.src_value  = '0;
      req_ch.size_code  = '0;
      req_ch.cond_code  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_logic_ops();
      test_shifts();
      test_rotate();
      test_not_and_setcc();
      test_odd_codes();
      test_backpressure();
      test_random(125, 0, 0);
      test_random(125, 53, 0);
      test_random(125, 0, 53);
      test_random(125, 36, 36);
      $display("tb: %0d instructions sent and %0d results checked", instrs_sent, results_seen);
      $display("tb: covered directed edge cases, a long receiver hold-off, four idle mixes");
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
